// File: hw/rtl/gaussian_bump_perturb_sphere_defines.svh
// Assertion macros shared by the perturbation block.
`ifndef GAUSSIAN_BUMP_PERTURB_SPHERE_DEFINES_SVH
`define GAUSSIAN_BUMP_PERTURB_SPHERE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define GBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset.
`define GBPS_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gbps_pkg.sv
package gbps_pkg;

   // One input word and one result word.
   typedef struct packed {
      logic signed [30:0] point_lat;
      logic signed [31:0] point_lon;
      logic signed [47:0] value_in;
   } req_word_type;

   typedef struct packed {
      logic signed [47:0] value_out;
      logic               saturated;
   } rsp_word_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_CENTRE_LAT      = 3'd0;
   localparam logic [2:0] CSR_CENTRE_LON      = 3'd1;
   localparam logic [2:0] CSR_AMPLITUDE       = 3'd2;
   localparam logic [2:0] CSR_WIDTH_KM        = 3'd3;
   localparam logic [2:0] CSR_EARTH_RADIUS_KM = 3'd4;

   localparam logic [23:0] WIDTH_RESET  = 24'd25600;
   localparam logic [15:0] RADIUS_RESET = 16'd6376;

   // Fixed-point constants, radians in Q29, fractions in Q30.
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] PI_Q29      = 31'd1686629713;
   localparam logic [30:0] HALF_PI_Q29 = 31'd843314857;
   localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;

   // Horner divisors of the sine series, highest term first.
   localparam int SIN_STEPS = 6;
   localparam int SIN_K [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};

   localparam int HORNER_LAT = 2;
   localparam int SIN_LAT    = 1 + SIN_STEPS * HORNER_LAT + 2;
   localparam int EXP_STEPS  = 12;
   localparam int THETA_BITS = 31;
   localparam int DIV_BITS   = 27;
   localparam int POW_CELLS  = 31;

   // exp(-1) in Q30, formed by the same truncating Horner steps as exp(-f).
   function automatic logic [30:0] exp_neg_one();
      logic [63:0] t;
      t = 64'h4000_0000;
      for (int k = EXP_STEPS; k >= 1; k--) begin
         t = 64'h4000_0000 - (t / 64'(k));
      end
      return t[30:0];
   endfunction

   localparam logic [30:0] E1_Q30 = exp_neg_one();

endpackage

// File: hw/rtl/gbps_horner_cell.sv
module gbps_horner_cell
   import gbps_pkg::*;
#(
   parameter int K = 1
) (
   input  logic        clock,
   input  logic [31:0] arg_in,
   input  logic [30:0] t_in,
   output logic [31:0] arg_out,
   output logic [30:0] t_out
);

   // Reciprocal of K, exact for every 33-bit dividend.
   localparam int          RECIP_SH = 33 + $clog2(K);
   localparam logic [33:0] RECIP    =
      34'(((68'd1 << RECIP_SH) + 68'(K) - 68'd1) / 68'(K));

   logic [63:0] prod;
   logic [32:0] m_ff;
   logic [66:0] qprod;
   logic [32:0] quot;
   logic [31:0] arg_ff;
   logic [31:0] arg2_ff;
   logic [30:0] t_ff;

   // Product with the running term, then the reciprocal multiply and subtract.
   assign prod  = 64'(arg_in) * 64'(t_in);
   assign qprod = 67'(m_ff) * 67'(RECIP);
   assign quot  = 33'(qprod >> RECIP_SH);

   always_ff @(posedge clock) begin
      m_ff    <= prod[62:30];
      arg_ff  <= arg_in;
      t_ff    <= Q30_ONE - quot[30:0];
      arg2_ff <= arg_ff;
   end

   assign arg_out = arg2_ff;
   assign t_out   = t_ff;

endmodule

// File: hw/rtl/gbps_sin.sv
module gbps_sin
   import gbps_pkg::*;
(
   input  logic        clock,
   input  logic [30:0] x_in,
   output logic [30:0] s_out,
   output logic [30:0] sq_out
);

   logic [61:0] x2_prod;
   logic [31:0] x2_ff;
   logic [30:0] x_d [SIN_STEPS*HORNER_LAT+1];
   logic [31:0] h_arg [SIN_STEPS+1];
   logic [30:0] h_t [SIN_STEPS+1];
   logic [61:0] s_prod;
   logic [30:0] s_ff;
   logic [61:0] sq_prod;
   logic [30:0] s2_ff;
   logic [30:0] sq_ff;

   // Square of the angle.
   assign x2_prod = 62'(x_in) * 62'(x_in);

   always_ff @(posedge clock) begin
      x2_ff  <= x2_prod[61:30];
      x_d[0] <= x_in;
   end

   // The angle waits beside the Horner chain.
   for (genvar i = 1; i <= SIN_STEPS*HORNER_LAT; i++) begin : g_xd
      always_ff @(posedge clock) begin
         x_d[i] <= x_d[i-1];
      end
   end

   assign h_arg[0] = x2_ff;
   assign h_t[0]   = Q30_ONE;

   for (genvar g = 0; g < SIN_STEPS; g++) begin : g_step
      gbps_horner_cell #(.K(SIN_K[g])) u_step (
         .clock   (clock),
         .arg_in  (h_arg[g]),
         .t_in    (h_t[g]),
         .arg_out (h_arg[g+1]),
         .t_out   (h_t[g+1])
      );
   end

   // Final multiply by the angle, then the square.
   assign s_prod  = 62'(x_d[SIN_STEPS*HORNER_LAT]) * 62'(h_t[SIN_STEPS]);
   assign sq_prod = 62'(s_ff) * 62'(s_ff);

   always_ff @(posedge clock) begin
      s_ff  <= s_prod[60:30];
      sq_ff <= sq_prod[60:30];
      s2_ff <= s_ff;
   end

   assign s_out  = s2_ff;
   assign sq_out = sq_ff;

endmodule

// File: hw/rtl/gbps_bisect_cell.sv
module gbps_bisect_cell
   import gbps_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [30:0] theta_in,
   input  logic [30:0] a_in,
   input  logic [47:0] val_in,
   output logic        valid_out,
   output logic [30:0] theta_out,
   output logic [30:0] a_out,
   output logic [47:0] val_out
);

   localparam logic [30:0] BIT_MASK = 31'd1 << BIT;

   logic [30:0] cand;
   logic [30:0] sq;
   logic        valid_d [SIN_LAT];
   logic [30:0] theta_d [SIN_LAT];
   logic [30:0] a_d [SIN_LAT];
   logic [47:0] val_d [SIN_LAT];
   logic [30:0] cand_d;
   logic        keep;
   logic        valid_ff;
   logic [30:0] theta_ff;
   logic [30:0] a_ff;
   logic [47:0] val_ff;

   // Try this bit of the half angle.
   assign cand = theta_in | BIT_MASK;

   gbps_sin u_sin (
      .clock  (clock),
      .x_in   (cand),
      .s_out  (),
      .sq_out (sq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d[0] <= 1'b0;
      end else begin
         valid_d[0] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      theta_d[0] <= theta_in;
      a_d[0]     <= a_in;
      val_d[0]   <= val_in;
   end

   // The word waits while the sine of the candidate is formed.
   for (genvar i = 1; i < SIN_LAT; i++) begin : g_wait
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_d[i] <= 1'b0;
         end else begin
            valid_d[i] <= valid_d[i-1];
         end
      end
      always_ff @(posedge clock) begin
         theta_d[i] <= theta_d[i-1];
         a_d[i]     <= a_d[i-1];
         val_d[i]   <= val_d[i-1];
      end
   end

   // Keep the bit when the candidate stays in range and its sine squared does not exceed the sum.
   assign cand_d = theta_d[SIN_LAT-1] | BIT_MASK;
   assign keep   = (cand_d <= PI_Q29) && (sq <= a_d[SIN_LAT-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_d[SIN_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      theta_ff <= keep ? cand_d : theta_d[SIN_LAT-1];
      a_ff     <= a_d[SIN_LAT-1];
      val_ff   <= val_d[SIN_LAT-1];
   end

   assign valid_out = valid_ff;
   assign theta_out = theta_ff;
   assign a_out     = a_ff;
   assign val_out   = val_ff;

endmodule

// File: hw/rtl/gaussian_bump_perturb_sphere.sv
// Throughput: one word per cycle; busy stays low, the pipeline of cells never stalls.
// Depth is set mostly by the 31 bisection cells of the angle search (one sine unit per
// cell), plus the 27 divider cells and the 31 exp(-1) power cells.
// Synchronous reset clears the valid chain and loads the register reset values.
module gaussian_bump_perturb_sphere
   import gbps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

`include "gaussian_bump_perturb_sphere_defines.svh"

   localparam logic signed [30:0] HALF_S = 31'sd843314857;
   localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;
   localparam int EXP_LAT = EXP_STEPS * HORNER_LAT;

   function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
      logic signed [30:0] r;
      r = v;
      if (v > HALF_S) begin
         r = HALF_S;
      end else if (v < -HALF_S) begin
         r = -HALF_S;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [30:0] centre_lat_ff;
   logic [31:0] centre_lon_ff;
   logic [17:0] amplitude_ff;
   logic [23:0] width_km_ff;
   logic [15:0] radius_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_lat_ff <= '0;
         centre_lon_ff <= '0;
         amplitude_ff  <= '0;
         width_km_ff   <= WIDTH_RESET;
         radius_ff     <= RADIUS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTRE_LAT:      centre_lat_ff <= csr_wdata[30:0];
            CSR_CENTRE_LON:      centre_lon_ff <= csr_wdata;
            CSR_AMPLITUDE:       amplitude_ff  <= csr_wdata[17:0];
            CSR_WIDTH_KM:        width_km_ff   <= csr_wdata[23:0];
            CSR_EARTH_RADIUS_KM: radius_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Front cell: clamp latitudes, wrap the longitude difference.
   logic signed [30:0] lp;
   logic signed [30:0] lc;
   logic [31:0]        dlat;
   logic [30:0]        lp_mag;
   logic [30:0]        lc_mag;
   logic [33:0]        lon_v;
   logic [33:0]        lon_w;
   logic               lon_ge;
   logic [32:0]        dlon;
   logic               v1_ff;
   logic [47:0]        val1_ff;
   logic [30:0]        hdlat_ff;
   logic [30:0]        hdlon_ff;
   logic [30:0]        cp_arg_ff;
   logic [30:0]        cc_arg_ff;

   assign lp     = clamp_lat(req_word.point_lat);
   assign lc     = clamp_lat($signed(centre_lat_ff));
   assign dlat   = 32'(lp) - 32'(lc);
   assign lp_mag = lp[30] ? 31'(-lp) : lp;
   assign lc_mag = lc[30] ? 31'(-lc) : lc;
   assign lon_v  = 34'($signed(req_word.point_lon)) - 34'($signed(centre_lon_ff))
                   + 34'(PI_Q29);
   assign lon_ge = !lon_v[33] && (lon_v[32:0] >= 33'(TWO_PI_Q29));
   assign lon_w  = lon_v[33] ? lon_v + 34'(TWO_PI_Q29)
                 : (lon_ge ? lon_v - 34'(TWO_PI_Q29) : lon_v);
   assign dlon   = 33'(lon_w[31:0]) - 33'(PI_Q29);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      val1_ff   <= req_word.value_in;
      hdlat_ff  <= dlat[31] ? 31'(-dlat) : dlat[30:0];
      hdlon_ff  <= dlon[32] ? 31'(-dlon) : dlon[30:0];
      cp_arg_ff <= 31'({HALF_PI_Q29 - lp_mag, 1'b0});
      cc_arg_ff <= 31'({HALF_PI_Q29 - lc_mag, 1'b0});
   end

   // Four sine units in parallel.
   logic [30:0] sq_lat;
   logic [30:0] sq_lon;
   logic [30:0] cos_p;
   logic [30:0] cos_c;

   gbps_sin u_sin_lat (.clock(clock), .x_in(hdlat_ff), .s_out(), .sq_out(sq_lat));
   gbps_sin u_sin_lon (.clock(clock), .x_in(hdlon_ff), .s_out(), .sq_out(sq_lon));
   gbps_sin u_cos_p (.clock(clock), .x_in(cp_arg_ff), .s_out(cos_p), .sq_out());
   gbps_sin u_cos_c (.clock(clock), .x_in(cc_arg_ff), .s_out(cos_c), .sq_out());

   logic        sv_ff [SIN_LAT];
   logic [47:0] sval_ff [SIN_LAT];

   for (genvar i = 0; i < SIN_LAT; i++) begin : g_sin_wait
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i] <= 1'b0;
         end else begin
            sv_ff[i] <= (i == 0) ? v1_ff : sv_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         sval_ff[i] <= (i == 0) ? val1_ff : sval_ff[(i == 0) ? 0 : i-1];
      end
   end

   // Haversine sum over three cells.
   logic [61:0] m1_prod;
   logic [30:0] m1_ff;
   logic [30:0] sqlat1_ff;
   logic [30:0] sqlon1_ff;
   logic [61:0] m2_prod;
   logic [30:0] m2_ff;
   logic [30:0] sqlat2_ff;
   logic [31:0] a_sum;
   logic [30:0] a_ff;
   logic        hv_ff [3];
   logic [47:0] hval_ff [3];

   assign m1_prod = 62'(cos_p) * 62'(cos_c);
   assign m2_prod = 62'(m1_ff) * 62'(sqlon1_ff);
   assign a_sum   = 32'(sqlat2_ff) + 32'(m2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff[0] <= 1'b0;
         hv_ff[1] <= 1'b0;
         hv_ff[2] <= 1'b0;
      end else begin
         hv_ff[0] <= sv_ff[SIN_LAT-1];
         hv_ff[1] <= hv_ff[0];
         hv_ff[2] <= hv_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      hval_ff[0] <= sval_ff[SIN_LAT-1];
      hval_ff[1] <= hval_ff[0];
      hval_ff[2] <= hval_ff[1];
      m1_ff      <= m1_prod[60:30];
      sqlat1_ff  <= sq_lat;
      sqlon1_ff  <= sq_lon;
      m2_ff      <= m2_prod[60:30];
      sqlat2_ff  <= sqlat1_ff;
      a_ff       <= (a_sum > 32'(Q30_ONE)) ? Q30_ONE : a_sum[30:0];
   end

   // Bisection cells, one bit of the half angle each, top bit first.
   logic        bv [THETA_BITS+1];
   logic [30:0] btheta [THETA_BITS+1];
   logic [30:0] ba [THETA_BITS+1];
   logic [47:0] bval [THETA_BITS+1];

   assign bv[0]     = hv_ff[2];
   assign btheta[0] = '0;
   assign ba[0]     = a_ff;
   assign bval[0]   = hval_ff[2];

   for (genvar g = 0; g < THETA_BITS; g++) begin : g_bisect
      gbps_bisect_cell #(.BIT(THETA_BITS - 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (bv[g]),
         .theta_in  (btheta[g]),
         .a_in      (ba[g]),
         .val_in    (bval[g]),
         .valid_out (bv[g+1]),
         .theta_out (btheta[g+1]),
         .a_out     (ba[g+1]),
         .val_out   (bval[g+1])
      );
   end

   // Distance, then the start of the ratio division.
   logic [46:0] d29_ff;
   logic        dv0_ff;
   logic [47:0] dval0_ff;
   logic [23:0] sig;
   logic [50:0] num;
   logic [50:0] sig_top;

   assign sig     = (width_km_ff == '0) ? 24'd1 : width_km_ff;
   assign num     = {1'b0, d29_ff, 3'b000};
   assign sig_top = {sig, 27'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_ff <= 1'b0;
      end else begin
         dv0_ff <= bv[THETA_BITS];
      end
   end

   always_ff @(posedge clock) begin
      d29_ff   <= 47'(radius_ff) * 47'(btheta[THETA_BITS]);
      dval0_ff <= bval[THETA_BITS];
   end

   // Restoring divider cells, one quotient bit each.
   logic        dv [DIV_BITS+1];
   logic [50:0] drem [DIV_BITS+1];
   logic [26:0] dq [DIV_BITS+1];
   logic        dfar [DIV_BITS+1];
   logic [47:0] dval [DIV_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv[0] <= 1'b0;
      end else begin
         dv[0] <= dv0_ff;
      end
   end

   always_ff @(posedge clock) begin
      drem[0] <= num;
      dq[0]   <= '0;
      dfar[0] <= num >= sig_top;
      dval[0] <= dval0_ff;
   end

   for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
      localparam int SH = DIV_BITS - 1 - g;
      logic [50:0] sh_sig;
      logic        ge;

      assign sh_sig = {27'b0, sig} << SH;
      assign ge     = drem[g] >= sh_sig;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv[g+1] <= 1'b0;
         end else begin
            dv[g+1] <= dv[g];
         end
      end
      always_ff @(posedge clock) begin
         drem[g+1] <= ge ? drem[g] - sh_sig : drem[g];
         dq[g+1]   <= dq[g] | (ge ? (27'd1 << SH) : 27'd0);
         dfar[g+1] <= dfar[g];
         dval[g+1] <= dval[g];
      end
   end

   // Square of the ratio, split into whole and fraction.
   logic [53:0] r_sq;
   logic        xv_ff;
   logic [4:0]  xn_ff;
   logic [29:0] xf_ff;
   logic        xfar_ff;
   logic [47:0] xval_ff;

   assign r_sq = 54'(dq[DIV_BITS]) * 54'(dq[DIV_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         xv_ff <= 1'b0;
      end else begin
         xv_ff <= dv[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      xn_ff   <= r_sq[53:49];
      xf_ff   <= {r_sq[48:25], 6'b0};
      xfar_ff <= dfar[DIV_BITS];
      xval_ff <= dval[DIV_BITS];
   end

   // exp(-f) through twelve Horner cells.
   logic [31:0] e_arg [EXP_STEPS+1];
   logic [30:0] e_t [EXP_STEPS+1];
   logic        ev_ff [EXP_LAT];
   logic [4:0]  en_ff [EXP_LAT];
   logic        efar_ff [EXP_LAT];
   logic [47:0] eval_ff [EXP_LAT];

   assign e_arg[0] = {2'b00, xf_ff};
   assign e_t[0]   = Q30_ONE;

   for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
      gbps_horner_cell #(.K(EXP_STEPS - g)) u_step (
         .clock   (clock),
         .arg_in  (e_arg[g]),
         .t_in    (e_t[g]),
         .arg_out (e_arg[g+1]),
         .t_out   (e_t[g+1])
      );
   end

   for (genvar i = 0; i < EXP_LAT; i++) begin : g_exp_wait
      always_ff @(posedge clock) begin
         if (reset) begin
            ev_ff[i] <= 1'b0;
         end else begin
            ev_ff[i] <= (i == 0) ? xv_ff : ev_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         en_ff[i]   <= (i == 0) ? xn_ff : en_ff[(i == 0) ? 0 : i-1];
         efar_ff[i] <= (i == 0) ? xfar_ff : efar_ff[(i == 0) ? 0 : i-1];
         eval_ff[i] <= (i == 0) ? xval_ff : eval_ff[(i == 0) ? 0 : i-1];
      end
   end

   // Power cells: cell g multiplies by exp(-1) when the whole part exceeds g.
   logic        pv [POW_CELLS+1];
   logic [30:0] pw [POW_CELLS+1];
   logic [4:0]  pn [POW_CELLS+1];
   logic [47:0] pval [POW_CELLS+1];

   assign pv[0]   = ev_ff[EXP_LAT-1];
   assign pw[0]   = efar_ff[EXP_LAT-1] ? 31'd0 : e_t[EXP_STEPS];
   assign pn[0]   = en_ff[EXP_LAT-1];
   assign pval[0] = eval_ff[EXP_LAT-1];

   for (genvar g = 0; g < POW_CELLS; g++) begin : g_pow
      logic [61:0] pprod;

      assign pprod = 62'(pw[g]) * 62'(E1_Q30);

      always_ff @(posedge clock) begin
         if (reset) begin
            pv[g+1] <= 1'b0;
         end else begin
            pv[g+1] <= pv[g];
         end
      end
      always_ff @(posedge clock) begin
         pw[g+1]   <= (pn[g] > 5'(g)) ? pprod[60:30] : pw[g];
         pn[g+1]   <= pn[g];
         pval[g+1] <= pval[g];
      end
   end

   // Scale the weight by the amplitude.
   logic [17:0] am_mag;
   logic [48:0] aw_prod;
   logic        awv_ff;
   logic [31:0] aw_ff;
   logic        aw_unit_ff;
   logic        aw_neg_ff;
   logic [47:0] awval_ff;

   assign am_mag  = amplitude_ff[17] ? 18'(-amplitude_ff) : amplitude_ff;
   assign aw_prod = 49'(am_mag) * 49'(pw[POW_CELLS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         awv_ff <= 1'b0;
      end else begin
         awv_ff <= pv[POW_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      aw_ff      <= aw_prod[47:16];
      aw_unit_ff <= (amplitude_ff == '0);
      aw_neg_ff  <= amplitude_ff[17];
      awval_ff   <= pval[POW_CELLS];
   end

   // Factor, magnitudes and result sign.
   logic [33:0] fac;
   logic        fv_ff;
   logic [31:0] mf_ff;
   logic [47:0] mv_ff;
   logic        neg_ff;
   logic        f_unit_ff;
   logic [47:0] fval_ff;

   assign fac = aw_neg_ff ? 34'(Q30_ONE) - 34'(aw_ff) : 34'(Q30_ONE) + 34'(aw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= awv_ff;
      end
   end

   always_ff @(posedge clock) begin
      mf_ff     <= fac[33] ? 32'(-fac) : fac[31:0];
      mv_ff     <= awval_ff[47] ? 48'(-awval_ff) : awval_ff;
      neg_ff    <= awval_ff[47] != fac[33];
      f_unit_ff <= aw_unit_ff;
      fval_ff   <= awval_ff;
   end

   // Two partial products of value by factor.
   logic        qv_ff;
   logic [63:0] p_ff;
   logic [63:0] q_ff;
   logic        qneg_ff;
   logic        q_unit_ff;
   logic [47:0] qval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 1'b0;
      end else begin
         qv_ff <= fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= 64'(mv_ff) * 64'(mf_ff[31:16]);
      q_ff      <= 64'(mv_ff) * 64'(mf_ff[15:0]);
      qneg_ff   <= neg_ff;
      q_unit_ff <= f_unit_ff;
      qval_ff   <= fval_ff;
   end

   // Sum, saturate and drive the result word.
   logic [64:0] low_sum;
   logic [50:0] prod;
   logic        sat;
   logic [47:0] res;
   logic        strobe_ff;
   logic [47:0] out_value_ff;
   logic        out_sat_ff;
   logic        out_unit_ff;
   logic [47:0] out_val_ff;

   assign low_sum = 65'({p_ff[13:0], 16'b0}) + 65'(q_ff);
   assign prod    = 51'(p_ff[63:14]) + 51'(low_sum[64:30]);

   always_comb begin
      sat = 1'b0;
      res = prod[47:0];
      if (qneg_ff) begin
         if (prod > 51'(SAT_NEG)) begin
            sat = 1'b1;
            res = SAT_NEG;
         end else begin
            res = 48'(-prod);
         end
      end else if (prod > 51'(SAT_POS)) begin
         sat = 1'b1;
         res = SAT_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= qv_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= res;
      out_sat_ff   <= sat;
      out_unit_ff  <= q_unit_ff;
      out_val_ff   <= qval_ff;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_word.value_out = out_value_ff;
   assign rsp_word.saturated = out_sat_ff;

   // A clamped result sits at one of the two range limits.
   `GBPS_ASSERT_NOW(a_sat_limit, clock, reset, rsp_strobe && rsp_word.saturated,
      (rsp_word.value_out == SAT_POS) || (rsp_word.value_out == SAT_NEG),
      "saturated result is not at a range limit")
   // With zero amplitude the value passes through unchanged.
   `GBPS_ASSERT_NOW(a_unit_gain, clock, reset, rsp_strobe && out_unit_ff,
      !rsp_word.saturated && (rsp_word.value_out == out_val_ff),
      "zero amplitude changed the value")
   // Reset loads the width and radius defaults.
   `GBPS_ASSERT_NEXT(a_reset_regs, clock, reset,
      (width_km_ff == WIDTH_RESET) && (radius_ff == RADIUS_RESET),
      "register defaults not loaded by reset")

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import gbps_pkg::*;

   localparam int LATENCY = 604;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   bit idle_on;
   int n_words;

   gaussian_bump_perturb_sphere dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicts the perturbed value of each accepted point and checks results in order.
   class bump_scoreboard;
      logic signed [30:0] c_lat;
      logic signed [31:0] c_lon;
      logic signed [17:0] amp;
      logic [23:0]        sigma;
      logic [15:0]        radius;
      rsp_word_type       pending[$];
      int                 errors;
      int                 checked;
      int                 n_sat;

      function new();
         c_lat  = '0;
         c_lon  = '0;
         amp    = '0;
         sigma  = WIDTH_RESET;
         radius = RADIUS_RESET;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_CENTRE_LAT:      c_lat  = v[30:0];
            CSR_CENTRE_LON:      c_lon  = v;
            CSR_AMPLITUDE:       amp    = v[17:0];
            CSR_WIDTH_KM:        sigma  = v[23:0];
            CSR_EARTH_RADIUS_KM: radius = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function longint lat_limit(longint v);
         if (v > longint'(HALF_PI_Q29)) return longint'(HALF_PI_Q29);
         if (v < -longint'(HALF_PI_Q29)) return -longint'(HALF_PI_Q29);
         return v;
      endfunction

      // Truncating Taylor sine in Q30.
      function logic [63:0] sine(logic [63:0] x);
         logic [63:0] x2, t;
         logic [63:0] divs [6];
         divs = '{156, 110, 72, 42, 20, 6};
         x2 = (x * x) >> 30;
         t = 64'd1 << 30;
         for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
         return (x * t) >> 30;
      endfunction

      function logic [63:0] sine_sq(logic [63:0] x);
         logic [63:0] s;
         s = sine(x);
         return (s * s) >> 30;
      endfunction

      function logic [63:0] decay(logic [63:0] f);
         logic [63:0] t;
         t = 64'd1 << 30;
         for (int k = 12; k >= 1; k--) t = (64'd1 << 30) - ((f * t) >> 30) / 64'(k);
         return t;
      endfunction

      function rsp_word_type predict(req_word_type w);
         longint lp, lc, plon, clon, val, am, wrap, fac;
         logic [63:0] hdlat, hdlon, cp, cc, a, theta, cand, d29, sg, ratio, x, n, e1, wt;
         logic [63:0] aw, mv, mf, fh, fl, p, q, prod;
         bit neg, sat;
         rsp_word_type r;
         lp   = lat_limit(longint'($signed(w.point_lat)));
         lc   = lat_limit(longint'(c_lat));
         plon = longint'($signed(w.point_lon));
         clon = longint'(c_lon);
         val  = longint'($signed(w.value_in));
         am   = longint'(amp);
         hdlat = magnitude(lp - lc);
         wrap = (plon - clon + longint'(PI_Q29)) % longint'(TWO_PI_Q29);
         if (wrap < 0) wrap += longint'(TWO_PI_Q29);
         hdlon = magnitude(wrap - longint'(PI_Q29));
         cp = sine(64'(longint'(HALF_PI_Q29) - longint'(magnitude(lp))) << 1);
         cc = sine(64'(longint'(HALF_PI_Q29) - longint'(magnitude(lc))) << 1);
         a = sine_sq(hdlat) + ((((cp * cc) >> 30) * sine_sq(hdlon)) >> 30);
         if (a > (64'd1 << 30)) a = 64'd1 << 30;
         // Bisection for the half central angle.
         theta = 0;
         for (int b = 30; b >= 0; b--) begin
            cand = theta | (64'd1 << b);
            if (cand <= 64'(PI_Q29) && sine_sq(cand) <= a) theta = cand;
         end
         d29 = 64'(radius) * theta;
         sg = (sigma == 0) ? 64'd1 : 64'(sigma);
         ratio = (d29 << 3) / sg;
         if (ratio >= (64'd8 << 24)) begin
            wt = 0;
         end else begin
            x = (ratio * ratio) >> 25;
            n = x >> 24;
            e1 = decay(64'd1 << 30);
            wt = decay((x & 64'hFF_FFFF) << 6);
            for (logic [63:0] i = 0; i < n; i++) wt = (wt * e1) >> 30;
         end
         aw = (magnitude(am) * wt) >> 16;
         fac = (am < 0) ? (longint'(1) << 30) - longint'(aw) : (longint'(1) << 30) + longint'(aw);
         neg = (val < 0) != (fac < 0);
         mv = magnitude(val);
         mf = magnitude(fac);
         fh = mf >> 16;
         fl = mf & 64'hFFFF;
         p = mv * fh;
         q = mv * fl;
         prod = (p >> 14) + ((((p & 64'h3FFF) << 16) + q) >> 30);
         sat = 0;
         if (neg) begin
            if (prod > (64'd1 << 47)) begin
               prod = 64'd1 << 47;
               sat = 1;
            end
            prod = -prod;
         end else if (prod > ((64'd1 << 47) - 1)) begin
            prod = (64'd1 << 47) - 1;
            sat = 1;
         end
         r.value_out = prod[47:0];
         r.saturated = sat;
         return r;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void note_point(req_word_type w);
         pending.push_back(predict(w));
      endfunction

      task check_result(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
         end else begin
            exp_w = pending.pop_front();
            checked++;
            if (got.saturated) n_sat++;
            if (got.value_out !== exp_w.value_out)
               report($sformatf("value_out got %h want %h", got.value_out, exp_w.value_out));
            if (got.saturated !== exp_w.saturated)
               report($sformatf("saturated got %b want %b", got.saturated, exp_w.saturated));
         end
      endtask
   endclass

   bump_scoreboard sb = new();

   // Clock.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels at each edge.
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_point(req_word);
      if (!reset && rsp_strobe) sb.check_result(rsp_word);
   end

   task send_point(logic [30:0] lat, logic [31:0] lon, logic [47:0] v);
      if (idle_on && $urandom_range(99) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{point_lat: lat, point_lon: lon, value_in: v};
      do @(posedge clock); while (busy);
      n_words++;
   endtask

   // Registers change only once the pipeline has drained.
   task drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 16) @(posedge clock);
   endtask

   // Writes follow back to back; the caller drops valid after the last one.
   task write_csr(logic [2:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task setup(logic [31:0] cl, logic [31:0] clon, logic [31:0] am, logic [31:0] wd,
              logic [31:0] rad);
      drain();
      write_csr(CSR_CENTRE_LAT, cl);
      write_csr(CSR_CENTRE_LON, clon);
      write_csr(CSR_AMPLITUDE, am);
      write_csr(CSR_WIDTH_KM, wd);
      write_csr(CSR_EARTH_RADIUS_KM, rad);
      csr_valid <= 1'b0;
   endtask

   function logic [47:0] rand_value();
      logic [47:0] v;
      int sh;
      v = 48'({$urandom, $urandom});
      sh = $urandom_range(47);
      if ($urandom_range(3) != 0) v = 48'($signed(v) >>> sh);
      return v;
   endfunction

   // Random points, mostly close to the centre so the weight varies.
   task random_points(int count);
      logic [30:0] lat;
      logic [31:0] lon;
      int k;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 6) begin
            k = $urandom_range(28, 6);
            lat = sb.c_lat + 31'($signed($urandom) >>> (31 - k));
            lon = sb.c_lon + 32'($signed($urandom) >>> (31 - k));
         end else begin
            lat = 31'($urandom);
            lon = $urandom;
         end
         idle_on = !(n_words > 900 && n_words < 1200);
         send_point(lat, lon, rand_value());
      end
   endtask

   task directed_points();
      send_point(31'sd0, 32'sd0, 48'h7FFF_FFFF_FFFF);
      send_point(31'sd0, 32'sd0, 48'h8000_0000_0000);
      send_point(31'h3FFF_FFFF, 32'h7FFF_FFFF, 48'h0000_0100_0000);
      send_point(31'h4000_0000, 32'h8000_0000, 48'hFFFF_FF00_0000);
      send_point(31'(HALF_PI_Q29), 32'(PI_Q29), 48'h1234_5678_9ABC);
      send_point(-31'(HALF_PI_Q29), -32'(PI_Q29), 48'h0);
      send_point(31'(HALF_PI_Q29) + 31'd1, 32'd0, 48'h0000_0000_0001);
      send_point(sb.c_lat, sb.c_lon + 32'(PI_Q29), 48'hFFFF_FFFF_FFFF);
      send_point(sb.c_lat, sb.c_lon, 48'h7FFF_FFFF_FFFF);
      send_point(sb.c_lat + 31'd1000, sb.c_lon - 32'd1000, 48'h8000_0000_0001);
      send_point(-sb.c_lat, sb.c_lon + 32'(TWO_PI_Q29), 48'h4000_0000_0000);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CENTRE_LAT;
      csr_wdata = '0;
      idle_on = 1'b1;
      n_words = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: amplitude zero leaves values untouched.
      directed_points();
      random_points(150);
      // Centre past the pole, zero width, full negative amplitude, largest radius.
      setup(32'h4000_0000, 32'h8000_0000, 32'h2_0000, 32'd0, 32'hFFFF);
      directed_points();
      random_points(350);
      // Largest values everywhere except a zero radius.
      setup(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h1_FFFF, 32'hFF_FFFF, 32'd0);
      directed_points();
      random_points(300);
      // Large amplitude to force saturation near the centre.
      setup(32'd300000000, 32'hC000_0000, 32'h1_FFFF, 32'd2560000, 32'd6376);
      directed_points();
      random_points(400);
      for (int ph = 0; ph < 2; ph++) begin
         setup($urandom, $urandom, $urandom, $urandom_range(32'hFF_FFFF, 1) >> $urandom_range(12),
               $urandom_range(65535, 1));
         directed_points();
         random_points(400);
      end
      drain();

      $display("Covered %0d points across six register settings, %0d results checked, %0d saturated.",
               n_words, sb.checked, sb.n_sat);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("Timeout with %0d results still expected", sb.pending.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/gbps_pkg.sv
hw/rtl/gbps_horner_cell.sv
hw/rtl/gbps_sin.sv
hw/rtl/gbps_bisect_cell.sv
hw/rtl/gaussian_bump_perturb_sphere.sv
verif/tb.sv
